// ===== hdl/scf_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo command framer package
// Shared types and constants for the frame builder, frame queue and serializer.
// ----------------------------------------------------------------------------
package scf_pkg;

	localparam int FrameBytes = 6;
	localparam int LenW       = 3;

	localparam logic [2:0] KIND_CONFIG   = 3'd0;
	localparam logic [2:0] KIND_SPEED    = 3'd1;
	localparam logic [2:0] KIND_POSITION = 3'd2;
	localparam logic [2:0] KIND_ABS      = 3'd3;
	localparam logic [2:0] KIND_SET_BASE = 3'd4;
	localparam logic [2:0] KIND_BLINK    = 3'd5;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_SERVO = 2'd1;
	localparam logic [1:0] STATUS_RANGE     = 2'd2;

	localparam logic [7:0] BYTE_START     = 8'h80;
	localparam logic [7:0] CMD_CONFIG     = 8'h00;
	localparam logic [7:0] CMD_SPEED      = 8'h01;
	localparam logic [7:0] CMD_POS_7BIT   = 8'h02;
	localparam logic [7:0] CMD_POS_8BIT   = 8'h03;
	localparam logic [7:0] CMD_ABS        = 8'h04;
	localparam logic [7:0] BYTE_BASE_MODE = 8'h02;
	localparam logic [7:0] BYTE_POS_HIGH  = 8'h01;
	localparam logic [7:0] BYTE_BLINK     = 8'h0f;

	localparam logic [12:0] ABS_MIN = 13'd500;
	localparam logic [12:0] ABS_MAX = 13'd5500;

	localparam logic [0:0] REG_DEVICE_ID     = 1'd0;
	localparam logic [0:0] REG_HIGHEST_SERVO = 1'd1;

	typedef struct packed {
		logic [FrameBytes-1:0][7:0] bytes;
		logic [LenW-1:0]            len;
		logic [1:0]                 status;
	} frame_t;

endpackage

// ===== hdl/scf_front.sv =====
// ----------------------------------------------------------------------------
// Servo command framer front end
// Checks one command request and builds its complete frame or error result.
// ----------------------------------------------------------------------------
module scf_front import scf_pkg::*; (
	input  logic [2:0]  kind,
	input  logic [7:0]  servo,
	input  logic [12:0] amount,
	input  logic        enable,
	input  logic        forward,
	input  logic [6:0]  device_id,
	input  logic [6:0]  highest_servo,
	output frame_t      frame
);

	logic over_15;
	logic over_127;
	logic abs_bad;
	logic servo_bad;
	logic [7:0] id_byte;

	assign over_15   = |amount[12:4];
	assign over_127  = |amount[12:7];
	assign abs_bad   = (amount > ABS_MAX) || (amount < ABS_MIN);
	assign servo_bad = servo > {1'b0, highest_servo};
	assign id_byte   = {1'b0, device_id};

	always_comb begin
		frame          = '0;
		frame.bytes[0] = BYTE_START;
		frame.status   = STATUS_OK;
		case (kind)
			KIND_SET_BASE: begin
				frame.bytes[1] = BYTE_BASE_MODE;
				frame.bytes[2] = {4'd0, amount[3:0]};
				frame.len      = 3'd3;
				if (over_15) begin
					frame.status = STATUS_RANGE;
				end
			end
			KIND_BLINK: begin
				frame.bytes[1] = BYTE_BASE_MODE;
				frame.bytes[2] = BYTE_BLINK;
				frame.len      = 3'd3;
			end
			KIND_CONFIG: begin
				frame.bytes[2] = CMD_CONFIG;
				frame.bytes[4] = {1'b0, enable, ~forward, 1'b0, amount[3:0]};
				frame.len      = 3'd5;
				if (over_15) begin
					frame.status = STATUS_RANGE;
				end
			end
			KIND_SPEED: begin
				frame.bytes[2] = CMD_SPEED;
				frame.bytes[4] = {1'b0, amount[6:0]};
				frame.len      = 3'd5;
				if (over_127) begin
					frame.status = STATUS_RANGE;
				end
			end
			KIND_POSITION: begin
				if (over_127) begin
					frame.bytes[2] = CMD_POS_8BIT;
					frame.bytes[4] = BYTE_POS_HIGH;
					frame.bytes[5] = {1'b0, amount[6:0]};
					frame.len      = 3'd6;
				end else begin
					frame.bytes[2] = CMD_POS_7BIT;
					frame.bytes[4] = {1'b0, amount[6:0]};
					frame.len      = 3'd5;
				end
			end
			KIND_ABS: begin
				frame.bytes[2] = CMD_ABS;
				frame.bytes[4] = {2'd0, amount[12:7]};
				frame.bytes[5] = {1'b0, amount[6:0]};
				frame.len      = 3'd6;
				if (abs_bad) begin
					frame.status = STATUS_RANGE;
				end
			end
			default: begin
				frame.status = STATUS_RANGE;
			end
		endcase
		if (kind <= KIND_ABS) begin
			frame.bytes[1] = id_byte;
			frame.bytes[3] = servo;
			if (servo_bad) begin
				frame.status = STATUS_BAD_SERVO;
			end
		end
		if (frame.status != STATUS_OK) begin
			frame.bytes = '0;
			frame.len   = 3'd1;
		end
	end

endmodule

// ===== hdl/scf_queue.sv =====
// ----------------------------------------------------------------------------
// Servo command framer frame queue
// Two-entry queue of built frames between the front end and the serializer.
// ----------------------------------------------------------------------------
module scf_queue import scf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t push_frame,
	input  logic   pop,
	output frame_t head_frame,
	output logic   empty,
	output logic   full
);

	frame_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign empty      = (count_q == 2'd0);
	assign full       = (count_q == 2'd2);
	assign head_frame = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("frame queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("frame queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("frame queue count out of bounds");

endmodule

// ===== hdl/scf_back.sv =====
// ----------------------------------------------------------------------------
// Servo command framer serializer
// Takes frames from the queue and emits them one byte per cycle.
// ----------------------------------------------------------------------------
module scf_back import scf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  frame_t      q_head,
	output logic        q_pop,
	output logic        result_valid,
	output logic [7:0]  frame_byte,
	output logic        last,
	output logic [1:0]  status
);

	frame_t          frm_q;
	logic [LenW-1:0] idx_q;
	logic            active_q;
	logic            at_last;

	assign at_last      = (idx_q == frm_q.len - 3'd1);
	assign q_pop        = (!active_q || at_last) && !q_empty;
	assign result_valid = active_q;
	assign frame_byte   = frm_q.bytes[idx_q];
	assign last         = active_q && at_last;
	assign status       = frm_q.status;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			frm_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (active_q && !at_last) begin
				idx_q <= idx_q + 3'd1;
			end else begin
				active_q <= 1'b0;
			end
		end
	end

	a_frame_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |=> (result_valid && $past(idx_q) + 3'd1 == idx_q))
		else $error("frame bytes not emitted back to back");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != STATUS_OK) |-> (last && frame_byte == 8'd0))
		else $error("error result is not a single zero byte");

endmodule

// ===== hdl/servo_command_framer.sv =====
// ----------------------------------------------------------------------------
// Servo command framer
// Turns servo command requests into serial frames, one byte per result.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The front end checks
// it and builds the whole frame in the same cycle, placing it in a two-entry
// queue. The serializer pulls frames from the queue and presents one byte per
// cycle on frame_byte, last and status, marked by result_valid for exactly one
// cycle; the receiver cannot stall it. The last byte of each frame has last
// set. A rejected request gives one result with byte zero, last set and a
// nonzero status.
// The first byte appears once the frame has passed the queue into the
// serializer's frame register, and the bytes of a frame follow on consecutive
// cycles. A frame has one, three, five or six bytes, which the serializer emits
// one byte a cycle; while the queue holds the next frame, frames follow with no gap.
// Busy is high while the queue holds two frames.
// Registers are written over the cfg channel, which is always ready. Reset
// empties the queue and loads device_id with 1 and highest_servo with 127.
// ----------------------------------------------------------------------------
module servo_command_framer import scf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [7:0]  servo,
	input  logic [12:0] amount,
	input  logic        enable,
	input  logic        forward,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	output logic        result_valid,
	output logic [7:0]  frame_byte,
	output logic        last,
	output logic [1:0]  status
);

	logic [6:0] device_id_q;
	logic [6:0] highest_servo_q;
	frame_t     new_frame;
	frame_t     head_frame;
	logic       push;
	logic       pop;
	logic       q_empty;
	logic       q_full;

	assign cfg_ready = 1'b1;
	assign busy      = q_full;
	assign push      = start && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q     <= 7'd1;
			highest_servo_q <= 7'd127;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEVICE_ID:     device_id_q     <= cfg_data;
				REG_HIGHEST_SERVO: highest_servo_q <= cfg_data;
				default:           device_id_q     <= device_id_q;
			endcase
		end
	end

	scf_front u_front (
		.kind          (kind),
		.servo         (servo),
		.amount        (amount),
		.enable        (enable),
		.forward       (forward),
		.device_id     (device_id_q),
		.highest_servo (highest_servo_q),
		.frame         (new_frame)
	);

	scf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (new_frame),
		.pop        (pop),
		.head_frame (head_frame),
		.empty      (q_empty),
		.full       (q_full)
	);

	scf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (head_frame),
		.q_pop        (pop),
		.result_valid (result_valid),
		.frame_byte   (frame_byte),
		.last         (last),
		.status       (status)
	);

endmodule

// ===== tb/servo_frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo frame checker
// Watches the request, register and result channels of the servo command
// framer. It keeps its own copy of the two registers, works out the frame
// bytes for every request transfer and compares each result transfer, field
// by field, with the oldest byte still awaited.
// ----------------------------------------------------------------------------
module servo_frame_checker import scf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  kind,
	input  logic [7:0]  servo,
	input  logic [12:0] amount,
	input  logic        enable,
	input  logic        forward,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        result_valid,
	input  logic [7:0]  frame_byte,
	input  logic        last,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          bytes_awaited
);

	localparam logic [12:0] SMALL_FIELD_MAX = 13'd15;
	localparam logic [12:0] SEVEN_BIT_MAX   = 13'd127;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [1:0] status;
	} frame_entry_t;

	frame_entry_t awaited_bytes[$];
	logic [6:0]   device_id;
	logic [6:0]   highest_servo;

	task automatic predict_frame(input logic [2:0] req_kind, input logic [7:0] req_servo,
			input logic [12:0] req_amount, input logic req_enable, input logic req_forward);
		logic [7:0] fb[6];
		int         len;
		logic [1:0] err;
		frame_entry_t entry;
		err = STATUS_OK;
		len = 0;
		fb[0] = BYTE_START;
		case (req_kind)
			KIND_SET_BASE: begin
				if (req_amount > SMALL_FIELD_MAX) begin
					err = STATUS_RANGE;
				end else begin
					fb[1] = BYTE_BASE_MODE;
					fb[2] = req_amount[7:0];
					len = 3;
				end
			end
			KIND_BLINK: begin
				fb[1] = BYTE_BASE_MODE;
				fb[2] = BYTE_BLINK;
				len = 3;
			end
			KIND_CONFIG, KIND_SPEED, KIND_POSITION, KIND_ABS: begin
				fb[1] = {1'b0, device_id};
				fb[3] = req_servo;
				if (req_servo > {1'b0, highest_servo}) begin
					err = STATUS_BAD_SERVO;
				end else begin
					case (req_kind)
						KIND_CONFIG: begin
							if (req_amount > SMALL_FIELD_MAX) begin
								err = STATUS_RANGE;
							end else begin
								fb[2] = CMD_CONFIG;
								fb[4] = {1'b0, req_enable, ~req_forward, req_amount[4:0]};
								len = 5;
							end
						end
						KIND_SPEED: begin
							if (req_amount > SEVEN_BIT_MAX) begin
								err = STATUS_RANGE;
							end else begin
								fb[2] = CMD_SPEED;
								fb[4] = req_amount[7:0];
								len = 5;
							end
						end
						KIND_POSITION: begin
							if (req_amount > SEVEN_BIT_MAX) begin
								fb[2] = CMD_POS_8BIT;
								fb[4] = BYTE_POS_HIGH;
								fb[5] = {1'b0, req_amount[6:0]};
								len = 6;
							end else begin
								fb[2] = CMD_POS_7BIT;
								fb[4] = req_amount[7:0];
								len = 5;
							end
						end
						default: begin
							if (req_amount > ABS_MAX || req_amount < ABS_MIN) begin
								err = STATUS_RANGE;
							end else begin
								fb[2] = CMD_ABS;
								fb[4] = {2'b00, req_amount[12:7]};
								fb[5] = {1'b0, req_amount[6:0]};
								len = 6;
							end
						end
					endcase
				end
			end
			default: begin
				err = STATUS_RANGE;
			end
		endcase
		if (err != STATUS_OK) begin
			entry = '{data: 8'h00, last: 1'b1, status: err};
			awaited_bytes.push_back(entry);
		end else begin
			for (int i = 0; i < len; i++) begin
				entry = '{data: fb[i], last: (i == len - 1), status: STATUS_OK};
				awaited_bytes.push_back(entry);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_entry_t want;
		if (!arst_n) begin
			device_id = 7'd1;
			highest_servo = 7'd127;
			awaited_bytes.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEVICE_ID:     device_id = cfg_data;
					REG_HIGHEST_SERVO: highest_servo = cfg_data;
					default: ;
				endcase
			end
			if (result_valid) begin
				if (awaited_bytes.size() == 0) begin
					$error("unexpected result: frame_byte %0h last %0b status %0d",
						frame_byte, last, status);
					fail_count++;
				end else begin
					want = awaited_bytes.pop_front();
					if (frame_byte !== want.data) begin
						$error("frame_byte: expected %0h, actual %0h", want.data, frame_byte);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, last);
						fail_count++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				predict_frame(kind, servo, amount, enable, forward);
			end
		end
		bytes_awaited = awaited_bytes.size();
	end

endmodule

// ===== tb/tb_servo_command_framer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo command framer testbench
// Drives directed and random command requests through the framer across
// several register settings and sender idle rates, while a checker module
// beside the block predicts every frame and compares the results.
// ----------------------------------------------------------------------------
module tb_servo_command_framer;
	import scf_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASES         = 4;
	localparam int PHASE_ITEMS    = 26;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic        busy;
	logic [2:0]  kind      = '0;
	logic [7:0]  servo     = '0;
	logic [12:0] amount    = '0;
	logic        enable    = 1'b0;
	logic        forward   = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = '0;
	logic [6:0]  cfg_data  = '0;
	logic        result_valid;
	logic [7:0]  frame_byte;
	logic        last;
	logic [1:0]  status;

	int          fail_count;
	int          bytes_awaited;
	int          quiet_cycles = 0;
	int          idle_percent = 0;
	logic [6:0]  cur_highest  = 7'd127;

	servo_command_framer u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .servo(servo), .amount(amount), .enable(enable), .forward(forward),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid), .frame_byte(frame_byte),
		.last(last), .status(status)
	);

	servo_frame_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .servo(servo), .amount(amount), .enable(enable), .forward(forward),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid), .frame_byte(frame_byte),
		.last(last), .status(status), .fail_count(fail_count),
		.bytes_awaited(bytes_awaited)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_request(input logic [2:0] k, input logic [7:0] sv,
			input logic [12:0] amt, input logic en, input logic fwd);
		while ($urandom_range(99) < idle_percent) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		servo <= sv;
		amount <= amt;
		enable <= en;
		forward <= fwd;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic send_random_request();
		logic [2:0]  k;
		logic [7:0]  sv;
		logic [12:0] amt;
		bit          in_range;
		k = ($urandom_range(99) < 5) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
		sv = ($urandom_range(99) < 75) ? 8'($urandom_range(0, cur_highest)) : 8'($urandom);
		in_range = ($urandom_range(99) < 80);
		amt = 13'($urandom);
		if (in_range) begin
			case (k)
				KIND_CONFIG, KIND_SET_BASE: amt = 13'($urandom_range(0, 15));
				KIND_SPEED:                 amt = 13'($urandom_range(0, 127));
				KIND_POSITION: begin
					if ($urandom_range(1)) amt = 13'($urandom_range(0, 127));
				end
				KIND_ABS:                   amt = 13'($urandom_range(ABS_MIN, ABS_MAX));
				default: ;
			endcase
		end
		send_request(k, sv, amt, 1'($urandom), 1'($urandom));
	endtask

	task automatic write_registers(input logic [6:0] dev_id, input logic [6:0] highest);
		cfg_valid <= 1'b1;
		cfg_index <= REG_DEVICE_ID;
		cfg_data <= dev_id;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= REG_HIGHEST_SERVO;
		cfg_data <= highest;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_highest = highest;
	endtask

	task automatic drain_frames();
		start <= 1'b0;
		@(posedge clk);
		while (bytes_awaited != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [6:0] phase_dev[PHASES];
		logic [6:0] phase_highest[PHASES];
		int         phase_idle[PHASES];
		phase_dev = '{7'd127, 7'd0, 7'($urandom), 7'($urandom)};
		phase_highest = '{7'd0, 7'd127, 7'($urandom), 7'($urandom_range(40, 127))};
		phase_idle = '{0, 58, 0, 33};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(KIND_CONFIG, 8'd0, 13'd0, 1'b0, 1'b1);
		send_request(KIND_CONFIG, 8'd127, 13'd15, 1'b1, 1'b0);
		send_request(KIND_CONFIG, 8'd5, 13'd16, 1'b1, 1'b1);
		send_request(KIND_CONFIG, 8'd128, 13'd3, 1'b0, 1'b0);
		send_request(KIND_SPEED, 8'd255, 13'd8191, 1'b1, 1'b1);
		send_request(KIND_SPEED, 8'd1, 13'd0, 1'b0, 1'b0);
		send_request(KIND_SPEED, 8'd2, 13'd127, 1'b0, 1'b0);
		send_request(KIND_SPEED, 8'd3, 13'd128, 1'b0, 1'b0);
		send_request(KIND_POSITION, 8'd4, 13'd0, 1'b0, 1'b0);
		send_request(KIND_POSITION, 8'd5, 13'd127, 1'b0, 1'b0);
		send_request(KIND_POSITION, 8'd6, 13'd128, 1'b0, 1'b0);
		send_request(KIND_POSITION, 8'd127, 13'd8191, 1'b1, 1'b1);
		send_request(KIND_ABS, 8'd7, 13'd499, 1'b0, 1'b0);
		send_request(KIND_ABS, 8'd8, 13'd500, 1'b0, 1'b0);
		send_request(KIND_ABS, 8'd9, 13'd5500, 1'b0, 1'b0);
		send_request(KIND_ABS, 8'd10, 13'd5501, 1'b0, 1'b0);
		send_request(KIND_ABS, 8'd11, 13'd0, 1'b0, 1'b0);
		send_request(KIND_ABS, 8'd12, 13'd8191, 1'b0, 1'b0);
		send_request(KIND_SET_BASE, 8'd0, 13'd0, 1'b0, 1'b0);
		send_request(KIND_SET_BASE, 8'd255, 13'd15, 1'b1, 1'b1);
		send_request(KIND_SET_BASE, 8'd0, 13'd16, 1'b0, 1'b0);
		send_request(KIND_SET_BASE, 8'd0, 13'd8191, 1'b0, 1'b0);
		send_request(KIND_BLINK, 8'd255, 13'd8191, 1'b1, 1'b1);
		send_request(3'd6, 8'd1, 13'd1, 1'b0, 1'b0);
		send_request(3'd7, 8'd255, 13'd8191, 1'b1, 1'b1);
		drain_frames();

		for (int p = 0; p < PHASES; p++) begin
			write_registers(phase_dev[p], phase_highest[p]);
			idle_percent = phase_idle[p];
			repeat (PHASE_ITEMS) send_random_request();
			drain_frames();
		end

		if (fail_count == 0 && bytes_awaited == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/scf_pkg.sv
hdl/scf_front.sv
hdl/scf_queue.sv
hdl/scf_back.sv
hdl/servo_command_framer.sv
tb/servo_frame_checker.sv
tb/tb_servo_command_framer.sv
